[rtl/rsd_pkg.sv]
// ----------------------------------------------------------------------------
// rsd_pkg
// shared types and constants of the run-skip-dump frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

  localparam int unsigned OffW      = 17;
  localparam int unsigned CntW      = 14;
  localparam int unsigned ResQDepth = 3;

  localparam logic [OffW-1:0] FrameReset = 17'd64000;
  localparam logic [OffW-1:0] OffsetCap  = 17'h1FFFF;

  // opcode byte of the long form
  localparam logic [7:0] OpLong = 8'h80;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_DONE  = 2'd2,
    CMD_ERROR = 2'd3
  } cmd_e;

  typedef enum logic [10:0] {
    PH_TYPE_LO  = 11'b000_0000_0001,
    PH_TYPE_HI  = 11'b000_0000_0010,
    PH_RAW      = 11'b000_0000_0100,
    PH_OP       = 11'b000_0000_1000,
    PH_DUMP     = 11'b000_0001_0000,
    PH_RUN_CNT  = 11'b000_0010_0000,
    PH_RUN_PIX  = 11'b000_0100_0000,
    PH_LONG_LO  = 11'b000_1000_0000,
    PH_LONG_HI  = 11'b001_0000_0000,
    PH_LRUN_PIX = 11'b010_0000_0000,
    PH_DRAIN    = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [15:0]     offset;
    logic [CntW-1:0] count;
    logic [7:0]      pixel;
    logic            last;
  } result_t;

endpackage

`default_nettype wire

[rtl/rsd_rec_if.sv]
// ----------------------------------------------------------------------------
// rsd_rec_if
// record byte channel: one byte of a frame record per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface rsd_rec_if;
  logic       valid;
  logic       ready;
  logic [7:0] record_byte;
  logic       record_end;

  modport source (output valid, output record_byte, output record_end, input ready);
  modport sink   (input valid, input record_byte, input record_end, output ready);
endinterface

`default_nettype wire

[rtl/rsd_res_if.sv]
// ----------------------------------------------------------------------------
// rsd_res_if
// decoder result channel: one pixel command or status per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface rsd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] pixel_offset;
  logic [13:0] fill_count;
  logic [7:0]  pixel_value;
  logic        final_result;

  modport source (
    output valid, output command, output pixel_offset, output fill_count,
    output pixel_value, output final_result, input ready
  );
  modport sink (
    input valid, input command, input pixel_offset, input fill_count,
    input pixel_value, input final_result, output ready
  );
endinterface

`default_nettype wire

[rtl/run_skip_dump_frame_decoder_unit.sv]
// ----------------------------------------------------------------------------
// run_skip_dump_frame_decoder_unit
// byte-serial decoder of raw and run-skip-dump frame records
// ----------------------------------------------------------------------------
// usage
//   rec_i carries one record byte per beat, record_end set on the last byte.
//   the record opens with a little-endian type word: 0 raw, 1 run-skip-dump.
//   res_o carries pixel writes, run fills and a closing done or error beat
//   (final_result set). a run leaves as one fill beat, skips give no beat.
//   cfg_we_i / cfg_wdata_i set frame_pixels; write only while the block idles.
// timing
//   one record byte is taken every cycle unless rec_i.ready is low; its
//   results join the registered queue behind waiting beats. a byte yields at
//   most two beats (a pixel and the closing status), so a raw record's last
//   byte gives an extra output beat. the parse update is an offset adder, a
//   decrement and compares between registers and a three-entry result queue.
// reset
//   rst_ni clears the parse state and the result queue, frame_pixels = 64000.
// stall
//   while res_o is held off the queue fills; rec_i.ready drops once fewer than
//   two queue slots would be free, so no result is ever lost.
// ----------------------------------------------------------------------------
`default_nettype none

module run_skip_dump_frame_decoder_unit
  import rsd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_PIXELS = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [OffW-1:0] cfg_wdata_i,
  rsd_rec_if.sink         rec_i,
  rsd_res_if.source       res_o
);

  localparam logic [31:0] MaxPix = 32'(MAX_FRAME_PIXELS);

  // configuration
  logic [OffW-1:0] frame_pixels_q;
  logic [OffW-1:0] limit;

  // parse state
  phase_e          phase_q, phase_d;
  logic [OffW-1:0] wr_off_q, wr_off_d;
  logic [CntW-1:0] remain_q, remain_d;
  logic [7:0]      word_lo_q, word_lo_d;
  logic            finished_q, finished_d;

  // datapath
  logic [15:0]     add_n;
  logic [OffW:0]   sum;
  logic [OffW-1:0] sum_sat;
  logic            wr_ok;
  logic            fill_ok;
  logic [15:0]     long_word;
  logic [CntW-1:0] remain_m1;
  logic [7:0]      rec_byte;

  // results of the current beat
  result_t         step_r, end_r, res0, res1;
  logic            step_v, end_v, res0_v, res1_v;
  logic [1:0]      n_res;

  // result queue
  result_t         q_q [ResQDepth];
  result_t         q_d [ResQDepth];
  logic [1:0]      cnt_q, cnt_d;
  logic [1:0]      base;
  logic            pop;
  logic            acc;

  assign rec_byte  = rec_i.record_byte;
  assign long_word = {rec_byte, word_lo_q};
  assign remain_m1 = remain_q - 1'b1;

  // limit in use: frame_pixels clipped to the build-time maximum
  assign limit = ({15'b0, frame_pixels_q} > MaxPix) ? MaxPix[OffW-1:0] : frame_pixels_q;

  // one shared adder for every offset advance
  always_comb begin
    unique case (phase_q)
      PH_RAW, PH_DUMP:         add_n = 16'd1;
      PH_OP:                   add_n = {9'b0, rec_byte[6:0]};
      PH_RUN_PIX, PH_LRUN_PIX: add_n = {2'b0, remain_q};
      PH_LONG_HI:              add_n = long_word;
      default:                 add_n = '0;
    endcase
  end

  assign sum     = {1'b0, wr_off_q} + (OffW+1)'(add_n);
  assign sum_sat = sum[OffW] ? OffsetCap : sum[OffW-1:0];
  assign wr_ok   = wr_off_q < limit;
  assign fill_ok = sum <= {1'b0, limit};

  // parse step for one record byte
  always_comb begin
    phase_d    = phase_q;
    wr_off_d   = wr_off_q;
    remain_d   = remain_q;
    word_lo_d  = word_lo_q;
    finished_d = finished_q;
    step_v     = 1'b0;
    step_r     = '{cmd: CMD_ERROR, offset: '0, count: '0, pixel: '0, last: 1'b1};
    end_v      = 1'b0;
    end_r      = '{cmd: CMD_ERROR, offset: '0, count: '0, pixel: '0, last: 1'b1};

    unique case (phase_q)
      PH_TYPE_LO: begin
        word_lo_d = rec_byte;
        phase_d   = PH_TYPE_HI;
      end
      PH_TYPE_HI: begin
        if (long_word == 16'd0) begin
          phase_d = PH_RAW;
        end else if (long_word == 16'd1) begin
          phase_d = PH_OP;
          // empty delta: frame unchanged
          if (rec_i.record_end) begin
            phase_d    = PH_DRAIN;
            finished_d = 1'b1;
          end
        end else begin
          step_v     = 1'b1;
          phase_d    = PH_DRAIN;
          finished_d = 1'b0;
        end
      end
      PH_RAW, PH_DUMP: begin
        if (wr_ok) begin
          step_v   = 1'b1;
          step_r   = '{cmd: CMD_WRITE, offset: wr_off_q[15:0], count: '0,
                       pixel: rec_byte, last: 1'b0};
          wr_off_d = sum_sat;
          if (phase_q == PH_DUMP) begin
            remain_d = remain_m1;
            if (remain_m1 == '0) begin
              phase_d = PH_OP;
            end
          end
        end else begin
          step_v     = 1'b1;
          phase_d    = PH_DRAIN;
          finished_d = 1'b0;
        end
      end
      PH_OP: begin
        priority if (rec_byte == 8'd0) begin
          phase_d = PH_RUN_CNT;
        end else if (!rec_byte[7]) begin
          remain_d = {6'b0, rec_byte};
          phase_d  = PH_DUMP;
        end else if (rec_byte == OpLong) begin
          phase_d = PH_LONG_LO;
        end else begin
          // short skip
          wr_off_d = sum_sat;
        end
      end
      PH_RUN_CNT: begin
        remain_d = {6'b0, rec_byte};
        phase_d  = PH_RUN_PIX;
      end
      PH_RUN_PIX, PH_LRUN_PIX: begin
        phase_d = PH_OP;
        if (remain_q != '0) begin
          if (fill_ok) begin
            step_v   = 1'b1;
            step_r   = '{cmd: CMD_FILL, offset: wr_off_q[15:0], count: remain_q,
                         pixel: rec_byte, last: 1'b0};
            wr_off_d = sum_sat;
          end else begin
            step_v     = 1'b1;
            phase_d    = PH_DRAIN;
            finished_d = 1'b0;
          end
        end
      end
      PH_LONG_LO: begin
        word_lo_d = rec_byte;
        phase_d   = PH_LONG_HI;
      end
      PH_LONG_HI: begin
        priority if (long_word == 16'd0) begin
          // stop code
          phase_d    = PH_DRAIN;
          finished_d = 1'b1;
        end else if (!long_word[15]) begin
          wr_off_d = sum_sat;
          phase_d  = PH_OP;
        end else if (!long_word[14]) begin
          remain_d = long_word[CntW-1:0];
          phase_d  = (long_word[CntW-1:0] != '0) ? PH_DUMP : PH_OP;
        end else begin
          remain_d = long_word[CntW-1:0];
          phase_d  = PH_LRUN_PIX;
        end
      end
      default: ;
    endcase

    // record end: closing status and return to the record start
    if (rec_i.record_end) begin
      unique case (phase_d)
        PH_RAW: begin
          end_v     = 1'b1;
          end_r.cmd = (wr_off_d == limit) ? CMD_DONE : CMD_ERROR;
        end
        PH_DRAIN: begin
          end_v     = finished_d;
          end_r.cmd = CMD_DONE;
        end
        PH_TYPE_LO, PH_TYPE_HI, PH_OP, PH_DUMP, PH_RUN_CNT, PH_RUN_PIX,
        PH_LONG_LO, PH_LONG_HI, PH_LRUN_PIX: begin
          end_v = 1'b1;
        end
        default: ;
      endcase
      phase_d    = PH_TYPE_LO;
      wr_off_d   = '0;
      remain_d   = '0;
      word_lo_d  = '0;
      finished_d = 1'b0;
    end
  end

  assign res0   = step_v ? step_r : end_r;
  assign res0_v = step_v | end_v;
  assign res1   = end_r;
  assign res1_v = step_v & end_v;
  assign n_res  = {res1_v, step_v ^ end_v};

  // result queue: head drives res_o, new beats land behind what remains
  assign pop         = (cnt_q != 2'd0) && res_o.ready;
  assign base        = cnt_q - {1'b0, pop};
  assign rec_i.ready = ~base[1];
  assign acc         = rec_i.valid && rec_i.ready;
  assign cnt_d       = base + (acc ? n_res : 2'd0);

  always_comb begin
    logic [1:0] slot;
    for (int i = 0; i < ResQDepth; i++) begin
      slot = 2'(i) - base;
      if (pop && (i < ResQDepth - 1)) begin
        q_d[i] = q_q[i+1];
      end else begin
        q_d[i] = q_q[i];
      end
      if (acc && res0_v && (slot == 2'd0)) begin
        q_d[i] = res0;
      end else if (acc && res1_v && (slot == 2'd1)) begin
        q_d[i] = res1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pixels_q <= FrameReset;
      phase_q        <= PH_TYPE_LO;
      wr_off_q       <= '0;
      remain_q       <= '0;
      word_lo_q      <= '0;
      finished_q     <= 1'b0;
      cnt_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        frame_pixels_q <= cfg_wdata_i;
      end
      if (acc) begin
        phase_q    <= phase_d;
        wr_off_q   <= wr_off_d;
        remain_q   <= remain_d;
        word_lo_q  <= word_lo_d;
        finished_q <= finished_d;
      end
      cnt_q <= cnt_d;
    end
  end

  // payload of the queue needs no reset
  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign res_o.valid        = cnt_q != 2'd0;
  assign res_o.command      = q_q[0].cmd;
  assign res_o.pixel_offset = q_q[0].offset;
  assign res_o.fill_count   = q_q[0].count;
  assign res_o.pixel_value  = q_q[0].pixel;
  assign res_o.final_result = q_q[0].last;

endmodule

`default_nettype wire

[rtl/rsd_checker.sv]
// ----------------------------------------------------------------------------
// rsd_checker
// port-level checks of the run-skip-dump frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_checker
  import rsd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [1:0]  command_i,
  input logic [15:0] pixel_offset_i,
  input logic [13:0] fill_count_i,
  input logic [7:0]  pixel_value_i,
  input logic        final_result_i
);

  // stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(command_i)
      && $stable(pixel_offset_i) && $stable(fill_count_i)
      && $stable(pixel_value_i) && $stable(final_result_i))
    else $error("stalled result beat changed");

  // closing beat is always done or error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && final_result_i |-> command_i == CMD_DONE || command_i == CMD_ERROR)
    else $error("final beat is not a status");

  // pixel commands never close a record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (command_i == CMD_WRITE || command_i == CMD_FILL) |-> !final_result_i)
    else $error("pixel command marked final");

  // empty runs give no fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && command_i == CMD_FILL |-> fill_count_i != 14'd0)
    else $error("fill with zero count");

endmodule

bind run_skip_dump_frame_decoder_unit rsd_checker u_rsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .command_i      (res_o.command),
  .pixel_offset_i (res_o.pixel_offset),
  .fill_count_i   (res_o.fill_count),
  .pixel_value_i  (res_o.pixel_value),
  .final_result_i (res_o.final_result)
);

`default_nettype wire
